>>> rtl/core/mwmsc_pkg.sv
// shared constants, types and codes of the mass window match score counter
`default_nettype none
package mwmsc_pkg;
   localparam int COLUMNS = 131072;
   localparam int SLOTS   = 1048576;
   localparam int ROWS    = 65536;

   localparam int COL_AW  = $clog2(COLUMNS);
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int ROW_AW  = $clog2(ROWS);

   localparam int CMD_W     = 3;
   localparam int POS_W     = 20;
   localparam int SLOT_W    = 21;
   localparam int ROW_ID_W  = 16;
   localparam int MASS_W    = 18;
   localparam int TOL_W     = 16;
   localparam int SCORE_W   = 15;
   localparam int COUNT_W   = 18;
   localparam int SHIFT_W   = 19;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 19;
   localparam int WIN_W     = 21;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_COL  = 3'd0,
      CMD_LOAD_SLOT = 3'd1,
      CMD_CLEAR     = 3'd2,
      CMD_PREFIX    = 3'd3,
      CMD_PRECURSOR = 3'd4,
      CMD_READ      = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMN_COUNT    = 2'd0,
      CSR_MASS_SHIFT      = 2'd1,
      CSR_PRECURSOR_BONUS = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic               we;
      logic [SCORE_W-1:0] value;
   } score_upd_type;
endpackage
`default_nettype wire

>>> rtl/core/mwmsc_if.sv
// channel interfaces: request, response and register write
`default_nettype none
interface mwmsc_req_if;
   import mwmsc_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [POS_W-1:0]    position;
   logic [SLOT_W-1:0]   first_slot;
   logic [SLOT_W-1:0]   next_slot;
   logic [ROW_ID_W-1:0] row_id;
   logic [MASS_W-1:0]   mass;
   logic [TOL_W-1:0]    tolerance;
   modport source (output valid, command, position, first_slot, next_slot, row_id, mass,
                   tolerance, input ready);
   modport sink (input valid, command, position, first_slot, next_slot, row_id, mass,
                 tolerance, output ready);
endinterface

interface mwmsc_rsp_if;
   import mwmsc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SCORE_W-1:0]  score;
   logic [ROW_ID_W-1:0] row_read;
   modport source (output valid, score, row_read, input ready);
   modport sink (input valid, score, row_read, output ready);
endinterface

interface mwmsc_csr_if;
   import mwmsc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mwmsc_score_unit.sv
// shared score update unit: plus one or precursor bonus, saturating
`default_nettype none
module mwmsc_score_unit (
   input  wire logic [mwmsc_pkg::SCORE_W-1:0] score,
   input  wire logic [mwmsc_pkg::SCORE_W-1:0] bonus,
   input  wire logic                          precursor,
   output mwmsc_pkg::score_upd_type           upd
);
   import mwmsc_pkg::*;

   logic [SCORE_W-1:0] addend;
   logic [SCORE_W:0]   sum;

   always_comb begin
      addend = precursor ? bonus : SCORE_W'(1);
      sum    = {1'b0, score} + {1'b0, addend};
      // precursor only lifts rows still under the bonus
      upd.we    = !precursor || (score < bonus);
      upd.value = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
   end
endmodule
`default_nettype wire

>>> rtl/core/mass_window_match_score_counter_core.sv
// top level: inverted index, score store and window walk sequencer
// each beat is handled on its own. loads, skipped queries and unused codes end in idle.
// a query that walks passes accept, two reads on the one column memory port, bound
// setup and a final slot test, plus a slot read, score read and score write for each
// index slot in its window. a score read is held while the previous response beat
// still waits on the output register.
// clearing scores sweeps all 65536 rows of the score memory one row a cycle, run once
// after reset and again for each clear beat; no request is taken meanwhile.
// register writes are always taken.
`default_nettype none
module mass_window_match_score_counter_core (
   input  wire logic    clock,
   input  wire logic    reset,
   mwmsc_req_if.sink    req_ch,
   mwmsc_rsp_if.source  rsp_ch,
   mwmsc_csr_if.sink    csr_ch
);
   import mwmsc_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_COL_L = 9'b000000100,
      S_COL_R = 9'b000001000,
      S_COL_W = 9'b000010000,
      S_SLOT  = 9'b000100000,
      S_ROW   = 9'b001000000,
      S_UPD   = 9'b010000000,
      S_READ  = 9'b100000000
   } state_type;

   // memories
   logic [2*SLOT_W-1:0] col_mem [COLUMNS];
   logic [ROW_ID_W-1:0] slot_mem [SLOTS];
   logic [SCORE_W-1:0]  score_mem [ROWS];

   // registers
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [SHIFT_W-1:0]   shift_ff;
   logic [SCORE_W-1:0]   bonus_ff;
   logic [COL_AW-1:0]    left_ff, left_in, right_ff, right_in;
   logic                 prec_ff, prec_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in, stop_ff, stop_in;
   logic [ROW_AW-1:0]    row_ff, row_in;
   logic [ROW_AW-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]   rsp_score_ff, rsp_score_in;
   logic [ROW_ID_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [2*SLOT_W-1:0]  col_q;
   logic [ROW_ID_W-1:0]  slot_q;
   logic [SCORE_W-1:0]   score_q;

   // memory controls
   logic                 col_we, col_re, slot_we, slot_re, sc_we, sc_re;
   logic [COL_AW-1:0]    col_ra;
   logic [SCORE_W-1:0]   sc_wd;
   logic [ROW_AW-1:0]    sc_wa, sc_ra;

   // window arithmetic
   logic                 accept;
   logic [COUNT_W:0]     cols_used;
   logic signed [WIN_W-1:0] cnt_s, m_s, mass_s, tol_s, pl_s, pr_s, ql_s, qr_s;
   logic signed [WIN_W-1:0] p_left, q_left, q_right;
   logic                 p_go, q_go;
   logic [SLOT_W-1:0]    stop_raw;
   logic                 row_ok;
   score_upd_type        upd;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.score    = rsp_score_ff;
   assign rsp_ch.row_read = rsp_row_ff;

   always_comb begin
      cols_used = ({1'b0, count_ff} < (COUNT_W+1)'(COLUMNS)) ? {1'b0, count_ff}
                                                           : (COUNT_W+1)'(COLUMNS);
      cnt_s  = $signed(WIN_W'(cols_used));
      mass_s = $signed(WIN_W'(req_ch.mass));
      tol_s  = $signed(WIN_W'(req_ch.tolerance));
      m_s    = mass_s + $signed({{(WIN_W-SHIFT_W){shift_ff[SHIFT_W-1]}}, shift_ff});
      // prefix window, shifted; skipped when the top edge is off the columns
      pl_s   = m_s - tol_s;
      pr_s   = m_s + tol_s;
      p_left = (pl_s < 0) ? '0 : pl_s;
      p_go   = (pr_s >= 0) && (pr_s < cnt_s);
      // precursor window, both edges clamped
      ql_s    = mass_s - tol_s;
      qr_s    = mass_s + tol_s;
      q_left  = (ql_s < 0) ? '0 : ql_s;
      q_right = (qr_s >= cnt_s) ? (cnt_s - WIN_W'(1)) : qr_s;
      q_go    = (q_left <= q_right);
   end

   assign stop_raw = col_q[SLOT_W-1:0];
   assign row_ok   = ({1'b0, slot_q} < (ROW_ID_W+1)'(ROWS));

   mwmsc_score_unit u_score (
      .score     (score_q),
      .bonus     (bonus_ff),
      .precursor (prec_ff),
      .upd       (upd)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      prec_in      = prec_ff;
      slot_in      = slot_ff;
      stop_in      = stop_ff;
      row_in       = row_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_score_in = rsp_score_ff;
      rsp_row_in   = rsp_row_ff;
      col_we  = 1'b0;
      col_re  = 1'b0;
      col_ra  = left_ff;
      slot_we = 1'b0;
      slot_re = 1'b0;
      sc_we   = 1'b0;
      sc_wa   = row_ff;
      sc_wd   = upd.value;
      sc_re   = 1'b0;
      sc_ra   = slot_q[ROW_AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            sc_we  = 1'b1;
            sc_wa  = clr_ff;
            sc_wd  = '0;
            clr_in = clr_ff + ROW_AW'(1);
            if (clr_ff == ROW_AW'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_ch.command)
                  CMD_LOAD_COL: begin
                     col_we = ({1'b0, req_ch.position} < (POS_W+1)'(COLUMNS));
                  end
                  CMD_LOAD_SLOT: begin
                     slot_we = ({1'b0, req_ch.position} < (POS_W+1)'(SLOTS));
                  end
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  CMD_PREFIX: begin
                     left_in  = p_left[COL_AW-1:0];
                     right_in = pr_s[COL_AW-1:0];
                     prec_in  = 1'b0;
                     if (p_go) begin
                        state_in = S_COL_L;
                     end
                  end
                  CMD_PRECURSOR: begin
                     left_in  = q_left[COL_AW-1:0];
                     right_in = q_right[COL_AW-1:0];
                     prec_in  = 1'b1;
                     if (q_go) begin
                        state_in = S_COL_L;
                     end
                  end
                  CMD_READ: begin
                     if ({1'b0, req_ch.position} < (POS_W+1)'(ROWS)) begin
                        sc_re    = 1'b1;
                        sc_ra    = req_ch.position[ROW_AW-1:0];
                        row_in   = req_ch.position[ROW_AW-1:0];
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_COL_L: begin
            col_re   = 1'b1;
            col_ra   = left_ff;
            state_in = S_COL_R;
         end
         S_COL_R: begin
            col_re   = 1'b1;
            col_ra   = right_ff;
            slot_in  = col_q[2*SLOT_W-1:SLOT_W];
            state_in = S_COL_W;
         end
         S_COL_W: begin
            // slots past the index end are not walked
            stop_in  = (stop_raw > SLOT_W'(SLOTS)) ? SLOT_W'(SLOTS) : stop_raw;
            state_in = S_SLOT;
         end
         S_SLOT: begin
            if (slot_ff < stop_ff) begin
               slot_re  = 1'b1;
               state_in = S_ROW;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ROW: begin
            if (row_ok) begin
               sc_re    = 1'b1;
               row_in   = slot_q[ROW_AW-1:0];
               state_in = S_UPD;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
               state_in = S_SLOT;
            end
         end
         S_UPD: begin
            sc_we    = upd.we;
            slot_in  = slot_ff + SLOT_W'(1);
            state_in = S_SLOT;
         end
         S_READ: begin
            // hold the read data until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = score_q;
               rsp_row_in   = ROW_ID_W'(row_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[req_ch.position[COL_AW-1:0]] <= {req_ch.first_slot, req_ch.next_slot};
      end
      if (col_re) begin
         col_q <= col_mem[col_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[req_ch.position[SLOT_AW-1:0]] <= req_ch.row_id;
      end
      if (slot_re) begin
         slot_q <= slot_mem[slot_ff[SLOT_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (sc_we) begin
         score_mem[sc_wa] <= sc_wd;
      end
      if (sc_re) begin
         score_q <= score_mem[sc_ra];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_W'(131072);
         shift_ff     <= '0;
         bonus_ff     <= SCORE_W'(10000);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_COLUMN_COUNT:    count_ff <= csr_ch.data[COUNT_W-1:0];
               CSR_MASS_SHIFT:      shift_ff <= csr_ch.data[SHIFT_W-1:0];
               CSR_PRECURSOR_BONUS: bonus_ff <= csr_ch.data[SCORE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      prec_ff      <= prec_in;
      slot_ff      <= slot_in;
      stop_ff      <= stop_in;
      row_ff       <= row_in;
      rsp_score_ff <= rsp_score_in;
      rsp_row_ff   <= rsp_row_in;
   end
endmodule
`default_nettype wire

>>> rtl/core/mwmsc_checker.sv
// port level checks of the core, bound to the top level
`default_nettype none
module mwmsc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [mwmsc_pkg::CMD_W-1:0]    req_command,
   input wire logic [mwmsc_pkg::POS_W-1:0]    req_position,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [mwmsc_pkg::SCORE_W-1:0]  rsp_score,
   input wire logic [mwmsc_pkg::ROW_ID_W-1:0] rsp_row_read
);
   import mwmsc_pkg::*;

   // the score sweep after reset blocks requests
   a_reset_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during reset sweep");

   // a clear beat always starts a sweep
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_CLEAR) |=> !req_ready)
      else $error("request taken during clear sweep");

   // a read of a row beyond the store gives no beat
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_READ &&
       {1'b0, req_position} >= (POS_W+1)'(ROWS) && !rsp_valid) |=> !rsp_valid)
      else $error("response for out of range row");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_score) &&
      $stable(rsp_row_read)))
      else $error("stalled response beat changed");
endmodule

bind mass_window_match_score_counter_core mwmsc_checker u_mwmsc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_command  (req_ch.command),
   .req_position (req_ch.position),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_score    (rsp_ch.score),
   .rsp_row_read (rsp_ch.row_read)
);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// testbench of the mass window match score counter: random beats checked by a predictor
module tb;
   import mwmsc_pkg::*;

   // the command field has two codes that the block must ignore
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   localparam int IDLE_LIMIT = 200000;  // a clear sweep alone covers all 65536 rows
   localparam int WALK_MAX   = 160;     // longest slot walk that a random query may cause
   localparam int MAX_CLEARS = 3;
   localparam int MASS_TOP   = 262143;

   typedef struct {
      logic [CMD_W-1:0]    command;
      logic [POS_W-1:0]    position;
      logic [SLOT_W-1:0]   first_slot;
      logic [SLOT_W-1:0]   next_slot;
      logic [ROW_ID_W-1:0] row_id;
      logic [MASS_W-1:0]   mass;
      logic [TOL_W-1:0]    tolerance;
   } match_request_type;

   typedef struct {
      logic [SCORE_W-1:0]  score;
      logic [ROW_ID_W-1:0] row_read;
   } score_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mwmsc_req_if req_ch();
   mwmsc_rsp_if rsp_ch();
   mwmsc_csr_if csr_ch();

   mass_window_match_score_counter_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // predictor state, updated as beats are accepted
   bit [SLOT_W-1:0]   ix_start  [COLUMNS];
   bit [SLOT_W-1:0]   ix_stop   [COLUMNS];
   bit [ROW_ID_W-1:0] ix_row    [SLOTS];
   bit [SCORE_W-1:0]  row_score [ROWS];
   bit [COUNT_W-1:0]         cur_count = COUNT_W'(131072);
   logic signed [SHIFT_W-1:0] cur_shift = '0;
   bit [SCORE_W-1:0]         cur_bonus = SCORE_W'(10000);

   // stimulus-side view of the index, updated as beats are queued,
   // so that no query ever reads an entry that was never written
   bit [SLOT_W-1:0]          pl_start   [COLUMNS];
   bit [SLOT_W-1:0]          pl_stop    [COLUMNS];
   bit                       pl_col_set [COLUMNS];
   bit                       pl_slot_set[SLOTS];
   bit [COUNT_W-1:0]         pl_count = COUNT_W'(131072);
   logic signed [SHIFT_W-1:0] pl_shift = '0;

   match_request_type pending_requests[$];
   score_reply_type   expected_scores[$];
   int                good_cols[$];
   int                row_pool[$];

   int errors       = 0;
   int beats_in     = 0;
   int scores_seen  = 0;
   int walks_done   = 0;
   int clears_queued = 0;
   int idle_cycles  = 0;

   // window of a query in columns; live is low when the query does nothing
   function automatic void window_of(input bit prefix, input logic [MASS_W-1:0] mass,
                                     input logic [TOL_W-1:0] tol,
                                     input bit [COUNT_W-1:0] count_reg,
                                     input logic signed [SHIFT_W-1:0] shift,
                                     output longint lo, output longint hi, output bit live);
      longint cnt, m;
      cnt = (count_reg < COLUMNS) ? longint'(count_reg) : longint'(COLUMNS);
      m = longint'(mass);
      if (prefix) m = m + longint'(shift);
      lo = m - longint'(tol);
      if (lo < 0) lo = 0;
      hi = m + longint'(tol);
      if (prefix) begin
         live = !(hi < 0 || hi >= cnt);
      end else begin
         if (hi >= cnt) hi = cnt - 1;
         live = (lo <= hi);
      end
   endfunction

   // walk the slots from the lower column start to the upper column stop
   task automatic score_window(input bit prefix, input longint lo, input longint hi);
      longint j, stop;
      int     s;
      j = ix_start[lo];
      stop = ix_stop[hi];
      if (stop > SLOTS) stop = SLOTS;
      walks_done++;
      // every 16-bit row id lies below ROWS here, so no slot is skipped
      for (; j < stop; j++) begin
         s = row_score[ix_row[j]];
         if (prefix) begin
            s = s + 1;
         end else if (s < cur_bonus) begin
            s = s + cur_bonus;
         end else begin
            continue;
         end
         if (s > SCORE_MAX) s = SCORE_MAX;
         row_score[ix_row[j]] = SCORE_W'(s);
      end
   endtask

   task automatic predict_request(input match_request_type q);
      longint lo, hi;
      bit     live;
      score_reply_type r;
      case (q.command)
         CMD_LOAD_COL: begin
            if (q.position < COLUMNS) begin
               ix_start[q.position] = q.first_slot;
               ix_stop[q.position]  = q.next_slot;
            end
         end
         CMD_LOAD_SLOT: begin
            if (q.position < SLOTS) ix_row[q.position] = q.row_id;
         end
         CMD_CLEAR: begin
            foreach (row_score[i]) row_score[i] = '0;
         end
         CMD_PREFIX, CMD_PRECURSOR: begin
            window_of(q.command == CMD_PREFIX, q.mass, q.tolerance, cur_count, cur_shift,
                      lo, hi, live);
            if (live) score_window(q.command == CMD_PREFIX, lo, hi);
         end
         CMD_READ: begin
            if (q.position < ROWS) begin
               r.score    = row_score[q.position];
               r.row_read = q.position[ROW_ID_W-1:0];
               expected_scores.insert(expected_scores.size(), r);
            end
         end
         default: ;
      endcase
   endtask

   // true when the query reads only written entries and walks a short range
   function automatic bit query_safe(input bit prefix, input logic [MASS_W-1:0] mass,
                                     input logic [TOL_W-1:0] tol);
      longint lo, hi, a, b;
      bit     live;
      window_of(prefix, mass, tol, pl_count, pl_shift, lo, hi, live);
      if (!live) return 1'b1;
      if (!pl_col_set[lo] || !pl_col_set[hi]) return 1'b0;
      a = pl_start[lo];
      b = pl_stop[hi];
      if (b > SLOTS) b = SLOTS;
      if (b - a > WALK_MAX) return 1'b0;
      for (longint j = a; j < b; j++)
         if (!pl_slot_set[j]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic match_request_type random_fields();
      match_request_type q;
      q.command    = CMD_W'($urandom);
      q.position   = POS_W'($urandom);
      q.first_slot = SLOT_W'($urandom);
      q.next_slot  = SLOT_W'($urandom);
      q.row_id     = ROW_ID_W'($urandom);
      q.mass       = MASS_W'($urandom);
      q.tolerance  = TOL_W'($urandom);
      return q;
   endfunction

   task automatic queue_request(input match_request_type q);
      if (q.command == CMD_LOAD_COL && q.position < COLUMNS) begin
         pl_start[q.position]   = q.first_slot;
         pl_stop[q.position]    = q.next_slot;
         pl_col_set[q.position] = 1'b1;
      end
      if (q.command == CMD_LOAD_SLOT && q.position < SLOTS) pl_slot_set[q.position] = 1'b1;
      if (q.command == CMD_CLEAR) clears_queued++;
      pending_requests.insert(pending_requests.size(), q);
   endtask

   task automatic queue_beat(input logic [CMD_W-1:0] cmd, input int pos, input int first,
                             input int nxt, input int row, input int mass, input int tol);
      match_request_type q;
      q = random_fields();
      q.command    = cmd;
      q.position   = POS_W'(pos);
      q.first_slot = SLOT_W'(first);
      q.next_slot  = SLOT_W'(nxt);
      q.row_id     = ROW_ID_W'(row);
      q.mass       = MASS_W'(mass);
      q.tolerance  = TOL_W'(tol);
      queue_request(q);
   endtask

   function automatic int pool_row();
      return row_pool[$urandom_range(0, row_pool.size() - 1)];
   endfunction

   task automatic queue_read(input int pos);
      match_request_type q;
      q = random_fields();
      q.command  = CMD_READ;
      q.position = POS_W'(pos);
      queue_request(q);
   endtask

   task automatic queue_col_load(input int pos);
      match_request_type q;
      q = random_fields();
      q.command    = CMD_LOAD_COL;
      q.position   = POS_W'(pos);
      q.first_slot = SLOT_W'($urandom_range(0, 120));
      // now and then a range that is empty or reversed
      if ($urandom_range(0, 9) == 0)
         q.next_slot = SLOT_W'($urandom_range(0, q.first_slot));
      else
         q.next_slot = q.first_slot + SLOT_W'($urandom_range(1, 6));
      queue_request(q);
   endtask

   // well-formed query near a loaded column, or a wild one now and then; a read if none is safe
   task automatic queue_query(input bit prefix);
      match_request_type q;
      int c, m;
      for (int attempt = 0; attempt < 8; attempt++) begin
         q = random_fields();
         q.command = prefix ? CMD_PREFIX : CMD_PRECURSOR;
         if ($urandom_range(0, 7) != 0) begin
            c = good_cols[$urandom_range(0, good_cols.size() - 1)];
            q.tolerance = ($urandom_range(0, 3) == 0) ? TOL_W'($urandom_range(0, 6))
                                                      : TOL_W'($urandom_range(0, 2));
            m = c + int'($urandom_range(0, 2)) - 1;
            if (prefix) m = m - int'(pl_shift);
            if (m < 0) m = 0;
            if (m > MASS_TOP) m = MASS_TOP;
            q.mass = MASS_W'(m);
         end
         if (query_safe(prefix, q.mass, q.tolerance)) begin
            queue_request(q);
            return;
         end
      end
      queue_read(pool_row());
   endtask

   task automatic random_stretch(input int n);
      match_request_type q;
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            q = random_fields();
            q.command = CMD_LOAD_SLOT;
            q.row_id  = ROW_ID_W'(pool_row());
            if ($urandom_range(0, 6) != 0) q.position = POS_W'($urandom_range(0, 127));
            queue_request(q);
         end else if (pick < 22) begin
            if ($urandom_range(0, 3) != 0) begin
               queue_col_load(good_cols[$urandom_range(0, good_cols.size() - 1)]);
            end else begin
               // wild bounds, mostly on columns that no query aims at
               q = random_fields();
               q.command = CMD_LOAD_COL;
               if (q.position < COLUMNS) q.position = POS_W'($urandom_range(70000, 120000));
               queue_request(q);
            end
         end else if (pick < 62) begin
            queue_query(1'b1);
         end else if (pick < 80) begin
            queue_query(1'b0);
         end else if (pick < 95) begin
            queue_read(($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 1048575))
                                                    : pool_row());
         end else if (pick < 98) begin
            q = random_fields();
            q.command = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
            queue_request(q);
         end else if (clears_queued < MAX_CLEARS && $urandom_range(0, 3) == 0) begin
            queue_beat(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            queue_read(pool_row());
         end
      end
      // closing read, so the block is known to be idle once its score is back
      queue_read(pool_row());
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_ch.valid || expected_scores.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock);
      while (!csr_ch.ready);
      case (idx)
         CSR_COLUMN_COUNT:    cur_count = value[COUNT_W-1:0];
         CSR_MASS_SHIFT:      cur_shift = value[SHIFT_W-1:0];
         CSR_PRECURSOR_BONUS: cur_bonus = value[SCORE_W-1:0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input int count, input int shift, input int bonus);
      pl_count = COUNT_W'(count);
      pl_shift = SHIFT_W'(shift);
      write_reg(CSR_COLUMN_COUNT, CSR_DAT_W'(count));
      write_reg(CSR_MASS_SHIFT, CSR_DAT_W'(shift));
      write_reg(CSR_PRECURSOR_BONUS, CSR_DAT_W'(bonus));
   endtask

   // request driver: one beat in flight, an idle gap of random length after each
   match_request_type on_wire;
   int  gap_left;
   bit  req_steady = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_request(on_wire);
            beats_in++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left     <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               on_wire = pending_requests.pop_front();
               req_ch.command    <= on_wire.command;
               req_ch.position   <= on_wire.position;
               req_ch.first_slot <= on_wire.first_slot;
               req_ch.next_slot  <= on_wire.next_slot;
               req_ch.row_id     <= on_wire.row_id;
               req_ch.mass       <= on_wire.mass;
               req_ch.tolerance  <= on_wire.tolerance;
               req_ch.valid      <= 1'b1;
               // stretches without gaps come and go
               if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
               gap_left <= req_steady ? 0 : $urandom_range(0, 5);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // score monitor: random stalls on ready, each beat checked against the oldest expectation
   int stall_left = 0;
   bit rsp_steady = 1'b0;
   score_reply_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            scores_seen++;
            if (expected_scores.size() == 0) begin
               $error("score beat with nothing expected: row_read %0d score %0d",
                      rsp_ch.row_read, rsp_ch.score);
               errors++;
            end else begin
               want = expected_scores.pop_front();
               if (rsp_ch.score !== want.score) begin
                  $error("score mismatch: expected %0d, actual %0d", want.score, rsp_ch.score);
                  errors++;
               end
               if (rsp_ch.row_read !== want.row_read) begin
                  $error("row_read mismatch: expected %0d, actual %0d",
                         want.row_read, rsp_ch.row_read);
                  errors++;
               end
            end
            if ($urandom_range(0, 19) == 0) rsp_steady = !rsp_steady;
            stall_left = rsp_steady ? 0 : $urandom_range(0, 5);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   // watchdog on cycles in which no channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.command    = CMD_READ;
      req_ch.position   = '0;
      req_ch.first_slot = '0;
      req_ch.next_slot  = '0;
      req_ch.row_id     = '0;
      req_ch.mass       = '0;
      req_ch.tolerance  = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_COLUMN_COUNT;
      csr_ch.data       = '0;

      row_pool.insert(row_pool.size(), 0);
      row_pool.insert(row_pool.size(), 65535);
      repeat (30) row_pool.insert(row_pool.size(), int'($urandom_range(0, 65535)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of slot and column bounds under the reset settings
      queue_beat(CMD_LOAD_SLOT, 0, 0, 0, 0, 0, 0);
      queue_beat(CMD_LOAD_SLOT, 1, 0, 0, 65535, 0, 0);
      queue_beat(CMD_LOAD_SLOT, 2, 0, 0, 7, 0, 0);
      queue_beat(CMD_LOAD_SLOT, 3, 0, 0, 12345, 0, 0);
      queue_beat(CMD_LOAD_SLOT, 1048575, 0, 0, 65535, 0, 0);
      queue_beat(CMD_LOAD_COL, 0, 0, 2, 0, 0, 0);
      queue_beat(CMD_LOAD_COL, 1, 2, 4, 0, 0, 0);
      queue_beat(CMD_LOAD_COL, 131071, 1, 4, 0, 0, 0);
      queue_beat(CMD_LOAD_COL, 5, 1048576, 1048576, 0, 0, 0);   // start at the slot limit
      queue_beat(CMD_LOAD_COL, 6, 1048575, 1048576, 0, 0, 0);   // last slot only
      queue_beat(CMD_LOAD_COL, 7, 2097151, 0, 0, 0, 0);         // reversed range
      queue_beat(CMD_LOAD_COL, 131072, 0, 1, 0, 0, 0);          // column out of range
      queue_beat(CMD_PREFIX, 0, 0, 0, 0, 0, 0);
      queue_beat(CMD_PRECURSOR, 0, 0, 0, 0, 0, 1);
      queue_beat(CMD_PREFIX, 0, 0, 0, 0, 6, 0);
      queue_beat(CMD_PREFIX, 0, 0, 0, 0, MASS_TOP, 65535);       // upper edge past columns
      queue_beat(CMD_PRECURSOR, 0, 0, 0, 0, MASS_TOP, 0);        // empty precursor window
      queue_beat(CMD_PRECURSOR, 0, 0, 0, 0, 131071, 0);
      queue_beat(CMD_PREFIX, 0, 0, 0, 0, 7, 0);
      queue_read(0);
      queue_read(65535);
      queue_read(12345);
      queue_read(1048575);                                       // row out of range
      queue_beat(CMD_SPARE_6, 0, 0, 0, 0, 0, 0);
      queue_beat(CMD_SPARE_7, 1, 1, 1, 1, 1, 1);
      queue_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      queue_read(65535);
      drain();

      // build a compact index: low slots, low columns and the top columns
      for (int s = 0; s < 128; s++) queue_beat(CMD_LOAD_SLOT, s, 0, 0, pool_row(), 0, 0);
      for (int c = 0; c < 48; c++) begin
         queue_col_load(c);
         good_cols.insert(good_cols.size(), c);
      end
      for (int c = COLUMNS - 32; c < COLUMNS; c++) begin
         queue_col_load(c);
         good_cols.insert(good_cols.size(), c);
      end
      random_stretch(220);
      drain();

      apply_settings(64, 0, 32767);
      random_stretch(200);
      drain();

      // no columns in use and a shift of -131072
      apply_settings(0, -131072, 0);
      random_stretch(120);
      drain();

      apply_settings(262143, 131072, 1);
      random_stretch(200);
      drain();

      apply_settings(40, int'($urandom_range(0, 16)) - 8, $urandom_range(0, 32767));
      random_stretch(200);
      drain();

      apply_settings($urandom_range(1, 131072), int'($urandom_range(0, 262144)) - 131072,
                     10000);
      random_stretch(200);
      drain();

      repeat (700) @(posedge clock);

      $display("run: %0d request beats, %0d score beats, %0d window walks, %0d clears",
               beats_in, scores_seen, walks_done, clears_queued);
      $display("settings covered: six register phases incl. zero and full column counts");
      if (errors == 0 && expected_scores.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (expected_scores.size() != 0)
            $error("%0d expected score beats never arrived", expected_scores.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
